// File: design/box_physics_tick_defines.svh
// assertion macros for the box physics tick block
`ifndef BOX_PHYSICS_TICK_DEFINES_SVH
`define BOX_PHYSICS_TICK_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPT_ASSERT_IMP(lbl, ante, cons, msg)
`define BPT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/bpt_pkg.sv
package bpt_pkg;

    localparam int POOL_SIZE  = 64;
    localparam int FRAC_BITS  = 8;
    localparam int ID_W       = 6;
    localparam int CNT_W      = 7;
    localparam int SZ_W       = 12;
    localparam int FIX_W      = SZ_W + FRAC_BITS;
    localparam int OVL_W      = FIX_W + 1;
    localparam int KIND_W     = 3;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE  = 3'd0,
        KIND_SET_POS = 3'd1,
        KIND_SET_VEL = 3'd2,
        KIND_SET_ACC = 3'd3,
        KIND_TICK    = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET,
        S_EMIT,
        S_T_RD,
        S_T_LD,
        S_T_MV,
        S_T_VA,
        S_T_MP,
        S_T_PA,
        S_T_CN,
        S_T_AE,
        S_T_COL,
        S_T_FIN,
        S_E_RD,
        S_E_OUT
    } t_state;

    // one entry of the box store
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] cor_x;
        logic signed [31:0] cor_y;
        logic [SZ_W-1:0]    w;
        logic [SZ_W-1:0]    h;
    } t_box;

    function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
        return $signed({{2{v[31]}}, v});
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            res = v[31:0];
        end else if (v[33]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7fff_ffff;
        end
        return res;
    endfunction

    // v * dt with round to nearest, ties up
    function automatic logic signed [32:0] mul_dt(input logic signed [31:0] v,
                                                  input logic [15:0] dt);
        logic signed [48:0] prod;
        prod = v * $signed({1'b0, dt});
        prod = prod + 49'sd32768;
        return prod[48:16];
    endfunction

    function automatic logic [FIX_W-1:0] fix_sz(input logic [SZ_W-1:0] s);
        return FIX_W'(s) << FRAC_BITS;
    endfunction

    function automatic logic [FIX_W-1:0] half_sz(input logic [SZ_W-1:0] s);
        return fix_sz(s) >> 1;
    endfunction

endpackage

// File: design/box_physics_tick.sv
// create and reject go through S_EMIT to the output register, a set first reads the store
// in S_SET; tick: each live box in turn is read and loaded, gets two multiply-accumulate
// steps, corner setup, a collision pass with one store read per live box, pipeline drain
// and write-back; then each report beat takes a store read and an output state
// throughput: one item at a time, one store read a cycle paces the collision pass
// reset: synchronous active low, clears live count, ground flag and handshake state
`include "box_physics_tick_defines.svh"
module box_physics_tick (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // box_id, value_x, value_y, box_width, box_height, time_step, zero pad
    input  logic [bpt_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // kind
    input  logic [bpt_pkg::KIND_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // result_id, pos_x, pos_y, grounded, zero pad
    output logic [bpt_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // rejected
    output logic                               o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    import bpt_pkg::*;

    // input fields
    logic [ID_W-1:0]    in_id;
    logic signed [31:0] in_vx, in_vy;
    logic [SZ_W-1:0]    in_w, in_h;
    logic [15:0]        in_dt;
    t_kind              in_kind;

    assign in_id   = i_s_axis_tdata[5:0];
    assign in_vx   = i_s_axis_tdata[37:6];
    assign in_vy   = i_s_axis_tdata[69:38];
    assign in_w    = i_s_axis_tdata[81:70];
    assign in_h    = i_s_axis_tdata[93:82];
    assign in_dt   = i_s_axis_tdata[109:94];
    assign in_kind = t_kind'(i_s_axis_tuser);

    // control and working registers
    t_state             r_state, n_state;
    t_box               r_box, n_box;
    logic [ID_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [CNT_W-1:0]   r_live, n_live;
    logic               r_ground, n_ground;
    logic               r_rej, n_rej;
    t_kind              r_kind, n_kind;
    logic signed [31:0] r_vx, n_vx, r_vy, n_vy;
    logic [15:0]        r_dt, n_dt;
    logic signed [32:0] r_mx, n_mx, r_my, n_my;
    logic signed [31:0] r_ax, n_ax, r_ay, n_ay;
    logic signed [33:0] r_ar, n_ar, r_at, n_at;

    // output register
    logic               r_ov, n_ov;
    logic [ID_W-1:0]    r_o_id, n_o_id;
    logic signed [31:0] r_o_px, n_o_px, r_o_py, n_o_py;
    logic               r_o_gnd, n_o_gnd, r_o_rej, n_o_rej, r_o_last, n_o_last;

    // box store
    t_box               r_mem [POOL_SIZE];
    t_box               r_rd;
    logic               wr_en, rd_en;
    logic [ID_W-1:0]    wr_addr, rd_addr;
    t_box               wr_data;

    // collision pipeline
    logic               col_issue;
    logic               r_s1_v;
    logic [ID_W-1:0]    r_s1_j;
    logic               r_s2_v, r_s2_self;
    logic signed [33:0] r_bl_x, r_bl_y, r_br_x, r_br_y;
    logic               r_s3_v, r_s3_self, r_s3_hit;
    logic [OVL_W-1:0]   r_ix, r_iy;
    logic signed [33:0] al_x, al_y, mx_l, my_l, mn_r, mn_t, ovx, ovy;
    logic               hit;
    logic               out_free;

    assign out_free = !r_ov || i_m_axis_tready;

    // store access, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // overlap of box i against the box read from the store
    always_comb begin
        al_x = ext34(r_ax);
        al_y = ext34(r_ay);
        hit  = (al_x < r_br_x) && (r_ar > r_bl_x) && (al_y < r_br_y) && (r_at > r_bl_y);
        mx_l = (al_x > r_bl_x) ? al_x : r_bl_x;
        my_l = (al_y > r_bl_y) ? al_y : r_bl_y;
        mn_r = (r_ar < r_br_x) ? r_ar : r_br_x;
        mn_t = (r_at < r_br_y) ? r_at : r_br_y;
        ovx  = mn_r - mx_l;
        ovy  = mn_t - my_l;
    end

    // collision pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= col_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
        r_s1_j    <= r_j[ID_W-1:0];
        r_s2_self <= (r_s1_j == r_i);
        r_bl_x    <= ext34(r_rd.cor_x);
        r_bl_y    <= ext34(r_rd.cor_y);
        r_br_x    <= ext34(r_rd.cor_x) + $signed(34'(fix_sz(r_rd.w)));
        r_br_y    <= ext34(r_rd.cor_y) + $signed(34'(fix_sz(r_rd.h)));
        r_s3_self <= r_s2_self;
        r_s3_hit  <= hit;
        r_ix      <= ovx[OVL_W-1:0];
        r_iy      <= ovy[OVL_W-1:0];
    end

    // sequencer: next state and store control
    always_comb begin
        logic               xpos, ypos;
        logic signed [33:0] dx, dy;
        n_state  = r_state;
        n_box    = r_box;
        n_i      = r_i;
        n_j      = r_j;
        n_live   = r_live;
        n_ground = r_ground;
        n_rej    = r_rej;
        n_kind   = r_kind;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_dt     = r_dt;
        n_mx     = r_mx;
        n_my     = r_my;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_ar     = r_ar;
        n_at     = r_at;
        n_ov     = r_ov && !i_m_axis_tready;
        n_o_id   = r_o_id;
        n_o_px   = r_o_px;
        n_o_py   = r_o_py;
        n_o_gnd  = r_o_gnd;
        n_o_rej  = r_o_rej;
        n_o_last = r_o_last;
        wr_en    = 1'b0;
        wr_addr  = r_i;
        wr_data  = r_box;
        rd_en    = 1'b0;
        rd_addr  = r_i;
        col_issue = 1'b0;
        xpos     = r_box.vel_x > 0;
        ypos     = r_box.vel_y > 0;
        dx       = $signed(34'(r_ix));
        dy       = $signed(34'(r_iy));
        o_s_axis_tready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind      = in_kind;
                    n_vx        = in_vx;
                    n_vy        = in_vy;
                    n_dt        = in_dt;
                    n_rej       = 1'b0;
                    n_box.pos_x = '0;
                    n_box.pos_y = '0;
                    n_i         = '0;
                    n_state     = S_EMIT;
                    case (in_kind)
                        KIND_CREATE: begin
                            if (r_live == CNT_W'(POOL_SIZE)) begin
                                n_rej = 1'b1;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = r_live[ID_W-1:0];
                                wr_data   = '0;
                                wr_data.w = in_w;
                                wr_data.h = in_h;
                                n_i       = r_live[ID_W-1:0];
                                n_live    = r_live + 1'b1;
                            end
                        end
                        KIND_SET_POS, KIND_SET_VEL, KIND_SET_ACC: begin
                            n_i = in_id;
                            if ({1'b0, in_id} >= r_live) begin
                                n_rej = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = in_id;
                                n_state = S_SET;
                            end
                        end
                        KIND_TICK: begin
                            if (r_live != '0) begin
                                n_state = S_T_RD;
                            end
                        end
                        default: begin
                            n_rej = 1'b1;
                        end
                    endcase
                end
            end
            S_SET: begin
                n_box = r_rd;
                case (r_kind)
                    KIND_SET_POS: begin
                        n_box.pos_x = r_vx;
                        n_box.pos_y = r_vy;
                    end
                    KIND_SET_VEL: begin
                        n_box.vel_x = r_vx;
                        n_box.vel_y = r_vy;
                    end
                    default: begin
                        n_box.acc_x = r_vx;
                        n_box.acc_y = r_vy;
                    end
                endcase
                wr_en   = 1'b1;
                wr_data = n_box;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_id   = r_i;
                    n_o_px   = r_box.pos_x;
                    n_o_py   = r_box.pos_y;
                    n_o_gnd  = r_ground;
                    n_o_rej  = r_rej;
                    n_o_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_T_RD: begin
                rd_en   = 1'b1;
                n_state = S_T_LD;
            end
            S_T_LD: begin
                n_box   = r_rd;
                n_state = S_T_MV;
            end
            // velocity update
            S_T_MV: begin
                n_mx    = mul_dt(r_box.acc_x, r_dt);
                n_my    = mul_dt(r_box.acc_y, r_dt);
                n_state = S_T_VA;
            end
            S_T_VA: begin
                n_box.vel_x = sat32(ext34(r_box.vel_x) + $signed({r_mx[32], r_mx}));
                n_box.vel_y = sat32(ext34(r_box.vel_y) + $signed({r_my[32], r_my}));
                n_state     = S_T_MP;
            end
            // position update
            S_T_MP: begin
                n_mx    = mul_dt(r_box.vel_x, r_dt);
                n_my    = mul_dt(r_box.vel_y, r_dt);
                n_state = S_T_PA;
            end
            S_T_PA: begin
                n_box.pos_x = sat32(ext34(r_box.pos_x) + $signed({r_mx[32], r_mx}));
                n_box.pos_y = sat32(ext34(r_box.pos_y) + $signed({r_my[32], r_my}));
                n_state     = S_T_CN;
            end
            // corner at the start of the collision pass
            S_T_CN: begin
                n_ax    = sat32(ext34(r_box.pos_x) - $signed(34'(half_sz(r_box.w))));
                n_ay    = sat32(ext34(r_box.pos_y) - $signed(34'(half_sz(r_box.h))));
                n_state = S_T_AE;
            end
            S_T_AE: begin
                n_ar    = ext34(r_ax) + $signed(34'(fix_sz(r_box.w)));
                n_at    = ext34(r_ay) + $signed(34'(fix_sz(r_box.h)));
                n_j     = '0;
                n_state = S_T_COL;
            end
            // stream every live box through the overlap pipeline
            S_T_COL: begin
                if (r_j < r_live) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_j[ID_W-1:0];
                    col_issue = 1'b1;
                    n_j       = r_j + 1'b1;
                end
                if (r_s3_v && !r_s3_self && r_s3_hit &&
                    !(r_box.vel_x == 0 && r_box.vel_y == 0)) begin
                    if (r_ix < r_iy) begin
                        n_box.pos_x = sat32(ext34(r_box.pos_x) + (xpos ? -dx : dx));
                        n_box.vel_x = '0;
                    end else begin
                        n_box.pos_y = sat32(ext34(r_box.pos_y) + (ypos ? -dy : dy));
                        n_box.vel_y = '0;
                    end
                    if (r_i == '0) begin
                        n_ground = ypos;
                    end
                end
                if (r_j == r_live && !r_s1_v && !r_s2_v && !r_s3_v) begin
                    n_state = S_T_FIN;
                end
            end
            // final corner and write-back
            S_T_FIN: begin
                n_box.cor_x = sat32(ext34(r_box.pos_x) - $signed(34'(half_sz(r_box.w))));
                n_box.cor_y = sat32(ext34(r_box.pos_y) - $signed(34'(half_sz(r_box.h))));
                wr_en       = 1'b1;
                wr_data     = n_box;
                if (CNT_W'(r_i) + 1'b1 == r_live) begin
                    n_i     = '0;
                    n_state = S_E_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_T_RD;
                end
            end
            // report pass
            S_E_RD: begin
                rd_en   = 1'b1;
                n_state = S_E_OUT;
            end
            S_E_OUT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_id   = r_i;
                    n_o_px   = r_rd.pos_x;
                    n_o_py   = r_rd.pos_y;
                    n_o_gnd  = r_ground;
                    n_o_rej  = 1'b0;
                    n_o_last = (CNT_W'(r_i) + 1'b1 == r_live);
                    if (CNT_W'(r_i) + 1'b1 == r_live) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_E_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_live   <= '0;
            r_ground <= 1'b0;
            r_ov     <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
        end else begin
            r_state  <= n_state;
            r_live   <= n_live;
            r_ground <= n_ground;
            r_ov     <= n_ov;
            r_i      <= n_i;
            r_j      <= n_j;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_box    <= n_box;
        r_rej    <= n_rej;
        r_kind   <= n_kind;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_dt     <= n_dt;
        r_mx     <= n_mx;
        r_my     <= n_my;
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_ar     <= n_ar;
        r_at     <= n_at;
        r_o_id   <= n_o_id;
        r_o_px   <= n_o_px;
        r_o_py   <= n_o_py;
        r_o_gnd  <= n_o_gnd;
        r_o_rej  <= n_o_rej;
        r_o_last <= n_o_last;
    end

    // result beat
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {1'b0, r_o_gnd, r_o_py, r_o_px, r_o_id};
    assign o_m_axis_tuser  = r_o_rej;
    assign o_m_axis_tlast  = r_o_last;

    // checks
    `BPT_ASSERT_IMP(a_live_bound, 1'b1, r_live <= CNT_W'(POOL_SIZE), "live count past pool")
    `BPT_ASSERT_NXT(a_create_grows,
        i_s_axis_tvalid && o_s_axis_tready && in_kind == KIND_CREATE &&
        r_live < CNT_W'(POOL_SIZE),
        r_live == $past(r_live) + 1'b1, "create did not add a box")
    `BPT_ASSERT_IMP(a_ok_id_live,
        o_m_axis_tvalid && !o_m_axis_tuser && r_live != '0,
        {1'b0, r_o_id} < r_live, "reported box not live")

endmodule

// File: tb/box_physics_tick_chk.sv
module box_physics_tick_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [bpt_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [bpt_pkg::KIND_W-1:0]     i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [bpt_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tuser,
    input  logic                           i_m_tlast,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_beats_seen,
    output int                             o_pushes_seen
);
    import bpt_pkg::*;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               gnd;
        logic               rej;
        logic               lst;
    } t_report;

    // shadow of the box pool
    int       sh_px [POOL_SIZE];
    int       sh_py [POOL_SIZE];
    int       sh_vx [POOL_SIZE];
    int       sh_vy [POOL_SIZE];
    int       sh_ax [POOL_SIZE];
    int       sh_ay [POOL_SIZE];
    int       sh_cx [POOL_SIZE];
    int       sh_cy [POOL_SIZE];
    longint   sh_w  [POOL_SIZE];
    longint   sh_h  [POOL_SIZE];
    int       boxes_live;
    logic     ground;
    t_report  reports_due[$];

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    // v*dt rounded to nearest, ties up
    function automatic longint scale_dt(input int v, input longint dt);
        longint p;
        p = longint'(v) * dt + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic void place_corner(input int i);
        sh_cx[i] = clamp32(longint'(sh_px[i]) - ((sh_w[i] << FRAC_BITS) >>> 1));
        sh_cy[i] = clamp32(longint'(sh_py[i]) - ((sh_h[i] << FRAC_BITS) >>> 1));
    endfunction

    function automatic void queue_report(input int id, input int px, input int py,
                                         input logic rej, input logic lst);
        t_report r;
        r.id  = id[ID_W-1:0];
        r.px  = px;
        r.py  = py;
        r.gnd = ground;
        r.rej = rej;
        r.lst = lst;
        reports_due.push_back(r);
    endfunction

    // euler step of one box, then push-back against the others
    function automatic void move_box(input int i, input longint dt);
        longint ax, ay, aw, ah, bx, by, bw, bh, ix, iy;
        logic   xpos, ypos;
        sh_vx[i] = clamp32(longint'(sh_vx[i]) + scale_dt(sh_ax[i], dt));
        sh_vy[i] = clamp32(longint'(sh_vy[i]) + scale_dt(sh_ay[i], dt));
        sh_px[i] = clamp32(longint'(sh_px[i]) + scale_dt(sh_vx[i], dt));
        sh_py[i] = clamp32(longint'(sh_py[i]) + scale_dt(sh_vy[i], dt));
        place_corner(i);
        ax = sh_cx[i];
        ay = sh_cy[i];
        aw = sh_w[i] << FRAC_BITS;
        ah = sh_h[i] << FRAC_BITS;
        for (int j = 0; j < boxes_live; j++) begin
            if (j == i || (sh_vx[i] == 0 && sh_vy[i] == 0)) continue;
            bx = sh_cx[j];
            by = sh_cy[j];
            bw = sh_w[j] << FRAC_BITS;
            bh = sh_h[j] << FRAC_BITS;
            if (!(ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by)) continue;
            ix = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ((ax > bx) ? ax : bx);
            iy = ((ay + ah < by + bh) ? ay + ah : by + bh) - ((ay > by) ? ay : by);
            xpos = sh_vx[i] > 0;
            ypos = sh_vy[i] > 0;
            if (ix < iy) begin
                sh_px[i] = clamp32(longint'(sh_px[i]) + (xpos ? -ix : ix));
                sh_vx[i] = 0;
            end else begin
                sh_py[i] = clamp32(longint'(sh_py[i]) + (ypos ? -iy : iy));
                sh_vy[i] = 0;
            end
            if (i == 0) ground = ypos;
            o_pushes_seen++;
        end
        place_corner(i);
    endfunction

    function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                         input logic [IN_DATA_W-1:0] d);
        int     id, vx, vy;
        longint dt;
        id = d[5:0];
        vx = d[37:6];
        vy = d[69:38];
        dt = d[109:94];
        case (kind)
            KIND_CREATE: begin
                if (boxes_live >= POOL_SIZE) begin
                    queue_report(0, 0, 0, 1'b1, 1'b1);
                end else begin
                    sh_w[boxes_live] = d[81:70];
                    sh_h[boxes_live] = d[93:82];
                    queue_report(boxes_live, sh_px[boxes_live], sh_py[boxes_live],
                                 1'b0, 1'b1);
                    boxes_live++;
                end
            end
            KIND_SET_POS, KIND_SET_VEL, KIND_SET_ACC: begin
                if (id >= boxes_live) begin
                    queue_report(id, 0, 0, 1'b1, 1'b1);
                end else begin
                    if (kind == KIND_SET_POS) begin
                        sh_px[id] = vx;
                        sh_py[id] = vy;
                    end else if (kind == KIND_SET_VEL) begin
                        sh_vx[id] = vx;
                        sh_vy[id] = vy;
                    end else begin
                        sh_ax[id] = vx;
                        sh_ay[id] = vy;
                    end
                    queue_report(id, sh_px[id], sh_py[id], 1'b0, 1'b1);
                end
            end
            KIND_TICK: begin
                for (int i = 0; i < boxes_live; i++) move_box(i, dt);
                if (boxes_live == 0) queue_report(0, 0, 0, 1'b0, 1'b1);
                for (int i = 0; i < boxes_live; i++)
                    queue_report(i, sh_px[i], sh_py[i], 1'b0, i + 1 == boxes_live);
            end
            default: queue_report(0, 0, 0, 1'b1, 1'b1);
        endcase
    endfunction

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_report r;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
                sh_px[i] = 0; sh_py[i] = 0; sh_vx[i] = 0; sh_vy[i] = 0;
                sh_ax[i] = 0; sh_ay[i] = 0; sh_cx[i] = 0; sh_cy[i] = 0;
                sh_w[i] = 0; sh_h[i] = 0;
            end
            boxes_live = 0;
            ground = 1'b0;
            reports_due.delete();
            o_fail_count = 0;
            o_beats_seen = 0;
            o_pushes_seen = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_beats_seen++;
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected result beat id=%0d pos=(%0d,%0d)", $time,
                             i_m_tdata[5:0], $signed(i_m_tdata[37:6]),
                             $signed(i_m_tdata[69:38]));
                    o_fail_count++;
                end else begin
                    r = reports_due.pop_front();
                    if (i_m_tdata[5:0] !== r.id || i_m_tdata[37:6] !== r.px ||
                        i_m_tdata[69:38] !== r.py || i_m_tdata[70] !== r.gnd ||
                        i_m_tuser !== r.rej || i_m_tlast !== r.lst) begin
                        $display("%0t: expected id=%0d pos=(%0d,%0d) gnd=%b rej=%b last=%b",
                                 $time, r.id, r.px, r.py, r.gnd, r.rej, r.lst);
                        $display("%0t: actual   id=%0d pos=(%0d,%0d) gnd=%b rej=%b last=%b",
                                 $time, i_m_tdata[5:0], $signed(i_m_tdata[37:6]),
                                 $signed(i_m_tdata[69:38]), i_m_tdata[70], i_m_tuser,
                                 i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) predict_item(i_s_tuser, i_s_tdata);
        end
        o_pending = reports_due.size();
    end

endmodule

// File: tb/box_physics_tick_tb.sv
module box_physics_tick_tb;
    import bpt_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    int                    fail_count;
    int                    pending;
    int                    beats_seen;
    int                    pushes_seen;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    boxes_made;
    int                    items_sent;
    int                    quiet_cycles;

    box_physics_tick i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    box_physics_tick_chk i_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_beats_seen  (beats_seen),
        .o_pushes_seen (pushes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side backpressure
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // stall watchdog: no beat on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_box_op(input logic [KIND_W-1:0] kind, input int id,
                               input logic [31:0] vx, input logic [31:0] vy,
                               input int w, input int h, input int dt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, dt[15:0], h[11:0], w[11:0], vy, vx, id[5:0]};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (kind == KIND_CREATE && boxes_made < POOL_SIZE) boxes_made++;
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // mostly small coordinates so boxes meet, now and then any 32-bit value
    function automatic logic [31:0] pick_coord(input int span);
        if ($urandom_range(7) == 0) return $urandom;
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic int pick_size();
        case ($urandom_range(9))
            0: return 0;
            1: return 4095;
            2: return $urandom_range(4095);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic send_random_op(input int grow_pct);
        int pick, id;
        pick = $urandom_range(99);
        id = (boxes_made > 0 && $urandom_range(9) != 0) ?
             $urandom_range(boxes_made - 1) : $urandom_range(63);
        if (pick < grow_pct)
            send_box_op(KIND_CREATE, 0, $urandom, $urandom, pick_size(), pick_size(),
                        $urandom);
        else if (pick < grow_pct + 25)
            send_box_op(KIND_SET_POS, id, pick_coord(12 * 256), pick_coord(12 * 256),
                        $urandom, $urandom, $urandom);
        else if (pick < grow_pct + 45)
            send_box_op(KIND_SET_VEL, id, pick_coord(6 * 256), pick_coord(6 * 256),
                        $urandom, $urandom, $urandom);
        else if (pick < grow_pct + 55)
            send_box_op(KIND_SET_ACC, id, pick_coord(4 * 256), pick_coord(4 * 256),
                        $urandom, $urandom, $urandom);
        else if (pick < 95)
            send_box_op(KIND_TICK, id, $urandom, $urandom, $urandom, $urandom,
                        ($urandom_range(5) == 0) ? $urandom : $urandom_range(4096, 32768));
        else
            send_box_op(KIND_W'($urandom_range(5, 7)), id, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = KIND_CREATE;
        send_idle_pct = 17;
        recv_idle_pct = 66;
        boxes_made    = 0;
        items_sent    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pool, bad ids, unknown kinds
        send_box_op(KIND_TICK, 0, 0, 0, 0, 0, 16'h8000);
        send_box_op(KIND_SET_POS, 63, 32'h7fffffff, 32'h80000000, 0, 0, 0);
        send_box_op(KIND_SET_VEL, 0, 1, 1, 0, 0, 0);
        send_box_op(3'd5, 9, 0, 0, 0, 0, 0);
        send_box_op(3'd6, 0, 0, 0, 0, 0, 0);
        send_box_op(3'd7, 63, 32'hffffffff, 32'hffffffff, 4095, 4095, 16'hffff);
        // size extremes and a small stack of boxes
        send_box_op(KIND_CREATE, 0, 0, 0, 4, 4, 0);
        send_box_op(KIND_CREATE, 0, 0, 0, 0, 0, 0);
        send_box_op(KIND_CREATE, 0, 0, 0, 4095, 4095, 0);
        send_box_op(KIND_CREATE, 0, 0, 0, 6, 2, 0);
        send_box_op(KIND_SET_POS, 2, 32'h7fffffff, 32'h80000000, 0, 0, 0);
        send_box_op(KIND_SET_POS, 3, 0, 5 * 256, 0, 0, 0);
        send_box_op(KIND_SET_POS, 0, 0, 2 * 256, 0, 0, 0);
        // box 0 falls onto box 3 with positive vertical speed
        send_box_op(KIND_SET_VEL, 0, 0, 3 * 256, 0, 0, 0);
        send_box_op(KIND_SET_ACC, 0, 0, 10 * 256, 0, 0, 0);
        send_box_op(KIND_TICK, 0, 0, 0, 0, 0, 16'h4000);
        // saturating speeds and the largest step
        send_box_op(KIND_SET_VEL, 1, 32'h7fffffff, 32'h80000000, 0, 0, 0);
        send_box_op(KIND_SET_ACC, 1, 32'h80000000, 32'h7fffffff, 0, 0, 0);
        send_box_op(KIND_TICK, 0, 0, 0, 0, 0, 16'hffff);
        send_box_op(KIND_TICK, 0, 0, 0, 0, 0, 0);
        // box 0 moving up into box 3 clears grounded
        send_box_op(KIND_SET_VEL, 0, 0, 32'hfffffd00, 0, 0, 0);
        send_box_op(KIND_SET_POS, 0, 0, 5 * 256, 0, 0, 0);
        send_box_op(KIND_TICK, 0, 0, 0, 0, 0, 16'h1000);
        drain_results();

        // random, first with the receiver stalling, then with the sender sparse
        repeat (25) send_random_op(15);
        drain_results();
        send_idle_pct = 66;
        recv_idle_pct = 17;
        repeat (25) send_random_op(15);
        drain_results();

        // full speed: fill the pool, overflow it, send eight random non-create items, then tick the whole pool
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (boxes_made < POOL_SIZE) send_random_op(80);
        send_box_op(KIND_CREATE, 0, 0, 0, 1, 1, 0);
        repeat (8) send_random_op(0);
        send_box_op(KIND_TICK, 0, 0, 0, 0, 0, 16'h2000);
        s_tvalid <= 1'b0;

        drain_results();
        repeat (50) @(negedge i_clk);
        $display("ran %0d input items, %0d result beats, %0d collision push-backs",
                 items_sent, beats_seen, pushes_seen);
        $display("covered empty and full pool, bad ids, unknown kinds, saturating motion");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
